### rtl/unique_word_indexer_defines.svh
// Assertion macros for the unique word indexer.
`ifndef UNIQUE_WORD_INDEXER_DEFINES_SVH
`define UNIQUE_WORD_INDEXER_DEFINES_SVH

// Implication checked on every rising edge, off while reset is active.
`define UWI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with the consequence in the following cycle.
`define UWI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/uwi_pkg.sv
// Shared constants and helpers of the unique word indexer.
`timescale 1ns / 1ps
package uwi_pkg;
	localparam int TEXT_DEPTH_DEF  = 2048;
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int QUEUE_DEPTH     = 4;

	// Fixed result field widths
	localparam int BYTE_W  = 8;
	localparam int ENTRY_W = 10;
	localparam int OFFS_W  = 11;
	localparam int WLEN_W  = 12;
	localparam int CNT_W   = 12;
	localparam int OUTC_W  = 2;
	localparam int RES_W   = ENTRY_W + OFFS_W + WLEN_W + CNT_W + OUTC_W;
	localparam int RES_PAD_W = ((RES_W + 7) / 8) * 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [BYTE_W-1:0] END_BYTE = 8'h00;

	typedef enum logic [OUTC_W-1:0] {
		OUTC_NEW     = 2'd0,
		OUTC_REPEAT  = 2'd1,
		OUTC_DROPPED = 2'd2
	} outcome_t;

	// Space, tab, newline, vertical tab, form feed, carriage return
	function automatic logic is_blank(input logic [BYTE_W-1:0] b);
		return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
	endfunction
endpackage

### rtl/unique_word_indexer.sv
// Flow: a byte is taken on each beat; a closing whitespace yields its result
// once the back end has walked the table entry by entry, compared the characters
// of entries of equal length pair by pair, and registered the outcome.
// Throughput: one byte per cycle while the 4-deep word queue has room.
// Reset: arst_n clears counters, queue and valid flags; text and table stores
// are not cleared and are only read where written.
`timescale 1ns / 1ps
`include "unique_word_indexer_defines.svh"
module unique_word_indexer #(
	parameter int TEXT_DEPTH  = uwi_pkg::TEXT_DEPTH_DEF,
	parameter int TABLE_DEPTH = uwi_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [uwi_pkg::BYTE_W-1:0]    s_tdata,   // text_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// entry_index[9:0], first_offset[20:10], word_size[32:21],
	// occurrences[44:33], outcome[46:45], zero pad
	output logic [uwi_pkg::RES_PAD_W-1:0] m_tdata
);
	import uwi_pkg::*;

	localparam int POS_W = $clog2(TEXT_DEPTH);
	localparam int LEN_W = POS_W + 1;
	localparam int CMD_W = POS_W + LEN_W;

	logic             push, pop, q_full, q_ne;
	logic [CMD_W-1:0] push_data, pop_data;
	logic             txt_we, txt_re;
	logic [POS_W-1:0] txt_waddr, txt_addr_a, txt_addr_b;
	logic [BYTE_W-1:0] txt_wdata, txt_data_a, txt_data_b;

	uwi_front #(.TEXT_DEPTH(TEXT_DEPTH)) u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.queue_full (q_full),
		.push, .push_data, .txt_we, .txt_waddr, .txt_wdata
	);

	uwi_queue #(.WIDTH(CMD_W)) u_queue (
		.clk, .arst_n, .push, .push_data,
		.pop, .pop_data, .full (q_full), .not_empty (q_ne)
	);

	// Two copies of the text so both words read a byte at the same time
	uwi_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_DEPTH)) u_text_a (
		.clk, .we (txt_we), .waddr (txt_waddr), .wdata (txt_wdata),
		.re (txt_re), .raddr (txt_addr_a), .rdata (txt_data_a)
	);
	uwi_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_DEPTH)) u_text_b (
		.clk, .we (txt_we), .waddr (txt_waddr), .wdata (txt_wdata),
		.re (txt_re), .raddr (txt_addr_b), .rdata (txt_data_b)
	);

	uwi_back #(.TEXT_DEPTH(TEXT_DEPTH), .TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk, .arst_n,
		.cmd_valid (q_ne), .cmd_data (pop_data), .cmd_pop (pop),
		.txt_re, .txt_addr_a, .txt_addr_b, .txt_data_a, .txt_data_b,
		.m_tvalid, .m_tready, .m_tdata
	);

	// Checks
	`UWI_ASSERT_IMPL(a_no_push_full, clk, arst_n, push, !q_full || pop, "queue overflow")
	`UWI_ASSERT_IMPL(a_drop_zero, clk, arst_n, m_tvalid && (m_tdata[46:45] == OUTC_DROPPED), (m_tdata[9:0] == '0) && (m_tdata[44:33] == '0), "drop fields")
	`UWI_ASSERT_IMPL(a_count_nz, clk, arst_n, m_tvalid && (m_tdata[46:45] != OUTC_DROPPED), m_tdata[44:33] != '0, "zero count")
	`UWI_ASSERT_NEXT(a_pop_once, clk, arst_n, pop, !pop, "back popped twice")
endmodule

### rtl/uwi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module uwi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/uwi_queue.sv
// Short FIFO of closed-word commands between front and back.
`timescale 1ns / 1ps
module uwi_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             not_empty
);
	import uwi_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      fill_q;

	assign full      = (fill_q == (PW+1)'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	// Payload slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end
endmodule

### rtl/uwi_front.sv
// Front: takes text bytes, stores them and queues closed words.
`timescale 1ns / 1ps
module uwi_front #(
	parameter int TEXT_DEPTH = uwi_pkg::TEXT_DEPTH_DEF,
	parameter int POS_W      = $clog2(TEXT_DEPTH),
	parameter int LEN_W      = POS_W + 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [uwi_pkg::BYTE_W-1:0] s_tdata,   // text_byte
	input  logic                      queue_full,
	output logic                      push,
	output logic [POS_W+LEN_W-1:0]    push_data,  // {length, offset}
	output logic                      txt_we,
	output logic [POS_W-1:0]          txt_waddr,
	output logic [uwi_pkg::BYTE_W-1:0] txt_wdata
);
	import uwi_pkg::*;

	logic [LEN_W-1:0] pos_q, pend_q;
	logic             ended_q;
	logic             beat, live, blank;
	logic [LEN_W-1:0] word_off;

	assign s_tready  = !queue_full;
	assign beat      = s_tvalid && s_tready;
	assign live      = beat && !ended_q && (s_tdata != END_BYTE);
	assign blank     = is_blank(s_tdata);
	assign word_off  = pos_q - pend_q;

	assign txt_we    = live;
	assign txt_waddr = pos_q[POS_W-1:0];
	assign txt_wdata = s_tdata;
	assign push      = live && blank && (pend_q != '0);
	assign push_data = {pend_q, word_off[POS_W-1:0]};

	// Position, pending word length and end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			pend_q  <= '0;
			ended_q <= 1'b0;
		end else if (beat && !ended_q) begin
			if (s_tdata == END_BYTE) begin
				ended_q <= 1'b1;
			end else begin
				if (!blank) pend_q <= pend_q + 1'b1;
				else        pend_q <= '0;
				pos_q <= pos_q + 1'b1;
				if (pos_q == LEN_W'(TEXT_DEPTH - 1)) ended_q <= 1'b1;
			end
		end
	end
endmodule

### rtl/uwi_back.sv
// Back: walks the word table, compares text and emits one result per word.
`timescale 1ns / 1ps
module uwi_back #(
	parameter int TEXT_DEPTH  = uwi_pkg::TEXT_DEPTH_DEF,
	parameter int TABLE_DEPTH = uwi_pkg::TABLE_DEPTH_DEF,
	parameter int POS_W       = $clog2(TEXT_DEPTH),
	parameter int LEN_W       = POS_W + 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic [POS_W+LEN_W-1:0]       cmd_data,
	output logic                         cmd_pop,
	output logic                         txt_re,
	output logic [POS_W-1:0]             txt_addr_a,
	output logic [POS_W-1:0]             txt_addr_b,
	input  logic [uwi_pkg::BYTE_W-1:0]   txt_data_a,
	input  logic [uwi_pkg::BYTE_W-1:0]   txt_data_b,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// entry_index, first_offset, word_size, occurrences, outcome
	output logic [uwi_pkg::RES_PAD_W-1:0] m_tdata
);
	import uwi_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int USED_W = IDX_W + 1;
	localparam int ENT_W  = CNT_W + LEN_W + POS_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ENT  = 7'b0000010,
		ST_ENTW = 7'b0000100,
		ST_CHR  = 7'b0001000,
		ST_CHW  = 7'b0010000,
		ST_HIT  = 7'b0100000,
		ST_MISS = 7'b1000000
	} bstate_t;

	bstate_t           state_q;
	logic [POS_W-1:0]  off_q;
	logic [LEN_W-1:0]  len_q, k_q;
	logic [USED_W-1:0] i_q, used_q;
	logic              out_free;

	logic              tbl_we, tbl_re;
	logic [IDX_W-1:0]  tbl_waddr;
	logic [ENT_W-1:0]  tbl_wdata, tbl_rdata;
	logic [POS_W-1:0]  ent_off;
	logic [LEN_W-1:0]  ent_len;
	logic [CNT_W-1:0]  ent_cnt, cnt_inc;
	logic              room;

	assign {ent_cnt, ent_len, ent_off} = tbl_rdata;
	assign cnt_inc  = (ent_cnt < COUNT_MAX) ? ent_cnt + 1'b1 : ent_cnt;
	assign room     = (used_q < USED_W'(TABLE_DEPTH));
	assign out_free = !m_tvalid || m_tready;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;

	// Character reads of the stored entry and of the new word
	assign txt_re     = (state_q == ST_CHR) && (k_q != len_q);
	assign txt_addr_a = ent_off + k_q[POS_W-1:0];
	assign txt_addr_b = off_q + k_q[POS_W-1:0];

	// Table reads and writes
	assign tbl_re = (state_q == ST_ENT) && (i_q < used_q);
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = i_q[IDX_W-1:0];
		tbl_wdata = {cnt_inc, ent_len, ent_off};
		if (state_q == ST_HIT) begin
			tbl_we = out_free;
		end else if (state_q == ST_MISS) begin
			tbl_we    = out_free && room;
			tbl_waddr = used_q[IDX_W-1:0];
			tbl_wdata = {CNT_W'(1), len_q, off_q};
		end
	end

	uwi_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (i_q[IDX_W-1:0]),
		.rdata (tbl_rdata)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			used_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						i_q     <= '0;
						state_q <= ST_ENT;
					end
				end
				ST_ENT: begin
					state_q <= (i_q < used_q) ? ST_ENTW : ST_MISS;
				end
				ST_ENTW: begin
					if (ent_len == len_q) begin
						k_q     <= '0;
						state_q <= ST_CHR;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_ENT;
					end
				end
				ST_CHR: begin
					state_q <= (k_q == len_q) ? ST_HIT : ST_CHW;
				end
				ST_CHW: begin
					if (txt_data_a == txt_data_b) begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_CHR;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_ENT;
					end
				end
				ST_HIT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				ST_MISS: begin
					if (out_free) begin
						if (room) used_q <= used_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Word command held during the walk
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			{len_q, off_q} <= cmd_data;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= (state_q == ST_HIT) || (state_q == ST_MISS);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && (state_q == ST_HIT)) begin
			m_tdata <= RES_PAD_W'({OUTC_REPEAT, cnt_inc, WLEN_W'(len_q),
				OFFS_W'(ent_off), ENTRY_W'(i_q)});
		end else if (out_free && (state_q == ST_MISS)) begin
			if (room) begin
				m_tdata <= RES_PAD_W'({OUTC_NEW, CNT_W'(1), WLEN_W'(len_q),
					OFFS_W'(off_q), ENTRY_W'(used_q)});
			end else begin
				m_tdata <= RES_PAD_W'({OUTC_DROPPED, CNT_W'(0), WLEN_W'(len_q),
					OFFS_W'(off_q), ENTRY_W'(0)});
			end
		end
	end
endmodule

### verif/tb_unique_word_indexer.sv
// Self-checking testbench for the unique word indexer: streams one text,
// predicts every word result and compares it against the result stream.
`timescale 1ns / 1ps
module tb_unique_word_indexer;
	import uwi_pkg::*;

	localparam int TXT_N   = 2048;
	localparam int TAB_N   = 1024;
	localparam int DIR_N   = 22;
	localparam int PLAN_N  = 1396;
	localparam int TAIL_N  = 150;
	localparam int WDOG    = 40000;
	localparam int PAUSE_AT = 300;
	localparam int HOLD_AT  = 600;
	localparam int HOLD_CYC = 400;

	// Result beat, highest field first
	typedef struct packed {
		outcome_t        outcome;
		logic [11:0]     occ;
		logic [11:0]     wlen;
		logic [10:0]     offs;
		logic [9:0]      idx;
	} word_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       chk;
		word_res_t  r;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [RES_PAD_W-1:0] m_tdata;

	always #5 clk = ~clk;

	unique_word_indexer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Predictor state
	logic [7:0]  txt [TXT_N];
	logic [10:0] ent_off [TAB_N];
	logic [11:0] ent_len [TAB_N];
	logic [11:0] ent_cnt [TAB_N];
	int unsigned n_entries = 0;
	int unsigned wr_pos = 0;
	int unsigned word_len = 0;
	bit          txt_done = 1'b0;

	word_res_t   pending_words[$];
	logic [7:0]  byte_plan[$];
	dir_row_t    dir_tab [DIR_N];
	int unsigned beats_in = 0;
	int unsigned errors = 0;
	int unsigned quiet = 0;

	function automatic bit blank_byte(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	// Word index update for one byte; returns 1 when a word closes
	function bit index_byte(input logic [7:0] b, output word_res_t r);
		int unsigned off, i, k;
		bit same;
		r = '0;
		if (txt_done || wr_pos >= TXT_N || b == 8'h00) begin
			txt_done = 1'b1;
			return 1'b0;
		end
		txt[wr_pos] = b;
		index_byte = 1'b0;
		if (!blank_byte(b)) begin
			word_len++;
		end else if (word_len > 0) begin
			off = wr_pos - word_len;
			index_byte = 1'b1;
			r = '{OUTC_DROPPED, 12'd0, word_len[11:0], off[10:0], 10'd0};
			for (i = 0; i < n_entries; i++) begin
				same = (ent_len[i] == word_len);
				for (k = 0; same && k < word_len; k++)
					same = (txt[ent_off[i] + k] == txt[off + k]);
				if (same) begin
					if (ent_cnt[i] != 12'hFFF)
						ent_cnt[i]++;
					r = '{OUTC_REPEAT, ent_cnt[i], word_len[11:0], ent_off[i], i[9:0]};
					break;
				end
			end
			if (r.outcome == OUTC_DROPPED && n_entries < TAB_N) begin
				ent_off[n_entries] = off[10:0];
				ent_len[n_entries] = word_len[11:0];
				ent_cnt[n_entries] = 12'd1;
				r = '{OUTC_NEW, 12'd1, word_len[11:0], off[10:0], n_entries[9:0]};
				n_entries++;
			end
			word_len = 0;
		end
		wr_pos++;
		if (wr_pos >= TXT_N)
			txt_done = 1'b1;
	endfunction

	// Input and result monitor
	always @(posedge clk) begin
		word_res_t r, e, got;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet = quiet + 1;
			if (s_tvalid && s_tready) begin
				if (index_byte(s_tdata, r)) begin
					if (beats_in < DIR_N && dir_tab[beats_in].chk)
						r = dir_tab[beats_in].r;
					pending_words.push_back(r);
				end
				beats_in <= beats_in + 1;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(word_res_t)-1:0];
				if (pending_words.size() == 0) begin
					$error("unexpected result beat %h", got);
					errors++;
				end else begin
					e = pending_words.pop_front();
					if (got.idx != e.idx) begin
						$error("entry_index exp %0d got %0d", e.idx, got.idx); errors++;
					end
					if (got.offs != e.offs) begin
						$error("first_offset exp %0d got %0d", e.offs, got.offs); errors++;
					end
					if (got.wlen != e.wlen) begin
						$error("word_size exp %0d got %0d", e.wlen, got.wlen); errors++;
					end
					if (got.occ != e.occ) begin
						$error("occurrences exp %0d got %0d", e.occ, got.occ); errors++;
					end
					if (got.outcome != e.outcome) begin
						$error("outcome exp %0d got %0d", e.outcome, got.outcome); errors++;
					end
				end
			end
			if (quiet >= WDOG) begin
				$display("unique_word_indexer regression: fail");
				$finish;
			end
		end
	end

	// Result side: random stall bursts, one long hold, none near the end
	initial begin
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && beats_in >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(negedge clk);
				m_tready <= 1'b1;
			end else if (byte_plan.size() > 0 && beats_in + TAIL_N < byte_plan.size()
					&& $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Text plan, byte driver and end of run
	initial begin
		logic [7:0] vocab [40][$];
		logic [7:0] w[$];
		logic [7:0] c;
		int unsigned n, i, j, wl;
		dir_tab = '{
			'{8'h20, 1'b0, '0},
			'{8'h61, 1'b0, '0},
			'{8'h20, 1'b1, '{OUTC_NEW, 12'd1, 12'd1, 11'd1, 10'd0}},
			'{8'h61, 1'b0, '0},
			'{8'h09, 1'b1, '{OUTC_REPEAT, 12'd2, 12'd1, 11'd1, 10'd0}},
			'{8'hFF, 1'b0, '0},
			'{8'h80, 1'b0, '0},
			'{8'h0A, 1'b1, '{OUTC_NEW, 12'd1, 12'd2, 11'd5, 10'd1}},
			'{8'h08, 1'b0, '0},
			'{8'h0E, 1'b0, '0},
			'{8'h0B, 1'b0, '0},
			'{8'h21, 1'b0, '0},
			'{8'h1F, 1'b0, '0},
			'{8'h0C, 1'b0, '0},
			'{8'hFF, 1'b0, '0},
			'{8'h80, 1'b0, '0},
			'{8'h0D, 1'b1, '{OUTC_REPEAT, 12'd2, 12'd2, 11'd5, 10'd1}},
			'{8'h7F, 1'b0, '0},
			'{8'h20, 1'b0, '0},
			'{8'h20, 1'b0, '0},
			'{8'h01, 1'b0, '0},
			'{8'h0A, 1'b0, '0}
		};
		for (i = 0; i < DIR_N; i++)
			byte_plan.push_back(dir_tab[i].b);
		// Vocabulary: mostly short words, a few long ones
		for (i = 0; i < 40; i++) begin
			wl = (i % 10 == 9) ? $urandom_range(20, 40) : $urandom_range(1, 6);
			for (j = 0; j < wl; j++) begin
				do c = 8'($urandom_range(1, 255)); while (blank_byte(c));
				vocab[i].push_back(c);
			end
		end
		// Random text; a space then closes the last word
		while (byte_plan.size() < PLAN_N) begin
			if ($urandom_range(0, 4) == 0) begin
				w.delete();
				wl = $urandom_range(1, 8);
				for (j = 0; j < wl; j++) begin
					do c = 8'($urandom_range(1, 255)); while (blank_byte(c));
					w.push_back(c);
				end
			end else begin
				w = vocab[$urandom_range(0, 39)];
			end
			foreach (w[k])
				if (byte_plan.size() < PLAN_N)
					byte_plan.push_back(w[k]);
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : 1;
			for (j = 0; j < n && byte_plan.size() < PLAN_N; j++) begin
				c = 8'($urandom_range(0, 5));
				byte_plan.push_back(c == 8'd5 ? 8'h20 : 8'h09 + c);
			end
		end
		byte_plan.push_back(8'h20);
		// Zero ends the text; the bytes after it are ignored
		byte_plan.push_back(8'h00);
		byte_plan.push_back(8'h61);
		byte_plan.push_back(8'h20);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		for (i = 0; i < byte_plan.size(); i++) begin
			if (i == PAUSE_AT) begin
				s_tvalid <= 1'b0;
				do @(negedge clk); while (pending_words.size() != 0);
			end else if (i + TAIL_N < byte_plan.size() && $urandom_range(0, 7) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= byte_plan[i];
			do @(negedge clk); while (beats_in == i);
		end
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_words.size() != 0);
		repeat (50) @(negedge clk);
		if (errors == 0) begin
			$display("unique_word_indexer regression: pass");
		end else begin
			$display("unique_word_indexer regression: fail");
		end
		$finish;
	end
endmodule
